/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file of the speed estimator.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also watches the reset cycles
`define ASSERT_CLK_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/esp_pkg.sv */
// Package of the encoder speed estimator: widths, constants and the
// request/response structs between the top level and the serial unit.
package esp_pkg;

    localparam int COUNT_WIDTH = 32;

    localparam int SCALE_W = 32;
    localparam int POS_W   = 32;
    localparam int TIME_W  = 32;
    localparam int RPM_W   = 32;

    // Position difference, wrapped to the counter width
    localparam int MOVE_W = (COUNT_WIDTH < POS_W + 1) ? COUNT_WIDTH : POS_W + 1;
    localparam int M2_W   = MOVE_W + 2;
    localparam int MAG_W  = MOVE_W + 1;
    localparam int CMPM_W = (MOVE_W > POS_W) ? MOVE_W : POS_W;
    localparam int PROD_W = SCALE_W + MAG_W;
    localparam int DEN_W  = TIME_W + 1;
    localparam int CMP_W  = (MAG_W > DEN_W) ? MAG_W : DEN_W;
    localparam int STEP_W = $clog2(SCALE_W);

    localparam int IN_TDATA_W  = POS_W + TIME_W + POS_W + TIME_W;
    localparam int OUT_TDATA_W = RPM_W;
    localparam int OUT_TUSER_W = 1;

    localparam logic [SCALE_W-1:0] RPM_SCALE_RESET = 32'd1893202;

    localparam logic signed [MOVE_W-1:0] BIG_POS = MOVE_W'(3);
    localparam logic signed [MOVE_W-1:0] BIG_NEG = MOVE_W'(-3);

    localparam logic signed [CMPM_W-1:0] MV_MAX = CMPM_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [CMPM_W-1:0] MV_MIN = CMPM_W'(-64'sh0000_0000_8000_0000);

    localparam logic [RPM_W-1:0] RPM_POS_LIM = 32'h7FFF_FFFF;
    localparam logic [RPM_W-1:0] RPM_NEG_LIM = 32'h8000_0000;

    typedef struct packed {
        logic               start;
        logic               mul;
        logic [SCALE_W-1:0] scale;
        logic [MAG_W-1:0]   mag;
        logic [DEN_W-1:0]   den;
    } t_unit_req;

    typedef struct packed {
        logic               done;
        logic               over;
        logic [SCALE_W-1:0] quo;
    } t_unit_rsp;

endpackage

/* hw/rtl/esp_serial_unit.sv */
// Bit-serial multiply (scale * magnitude) followed by a restoring divide with
// quotient overflow check. Depends on esp_pkg.
module esp_serial_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  esp_pkg::t_unit_req i_req,
    output esp_pkg::t_unit_rsp o_rsp
);
    import esp_pkg::*;

    typedef enum logic [1:0] {U_IDLE, U_MUL, U_CHK, U_DIV} t_ustate;

    t_ustate             r_state;
    logic [STEP_W-1:0]   r_cnt;
    logic [PROD_W-1:0]   r_acc;
    logic [MAG_W-1:0]    r_mag;
    logic [DEN_W-1:0]    r_den;
    logic [DEN_W-1:0]    r_rem;
    logic                r_done;
    logic                r_over;

    logic [MAG_W-1:0]    acc_hi;
    logic [MAG_W:0]      mul_sum;
    logic [PROD_W-1:0]   n_acc_mul;
    logic                hi_ge;
    logic [DEN_W:0]      div_tmp;
    logic [DEN_W:0]      div_diff;
    logic                div_ge;
    logic [DEN_W-1:0]    n_rem;
    logic                cnt_last;

    assign acc_hi    = r_acc[PROD_W-1:SCALE_W];
    // add the multiplicand into the top when the current multiplier bit is set
    assign mul_sum   = {1'b0, acc_hi} + {1'b0, r_mag & {MAG_W{r_acc[0]}}};
    assign n_acc_mul = {mul_sum, r_acc[SCALE_W-1:1]};

    // quotient needs more than 32 bits when the upper half reaches the divisor
    assign hi_ge    = CMP_W'(acc_hi) >= CMP_W'(r_den);

    assign div_tmp  = {r_rem, r_acc[SCALE_W-1]};
    assign div_ge   = div_tmp >= {1'b0, r_den};
    assign div_diff = div_tmp - {1'b0, r_den};
    assign n_rem    = div_ge ? div_diff[DEN_W-1:0] : div_tmp[DEN_W-1:0];

    assign cnt_last = r_cnt == STEP_W'(SCALE_W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= ((r_state == U_CHK) && hi_ge) || ((r_state == U_DIV) && cnt_last);
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_acc   <= {MAG_W'(0), i_req.scale};
                        r_mag   <= i_req.mag;
                        r_den   <= i_req.den;
                        r_cnt   <= '0;
                        r_state <= i_req.mul ? U_MUL : U_CHK;
                    end
                end
                U_MUL: begin
                    r_acc <= n_acc_mul;
                    r_cnt <= r_cnt + STEP_W'(1);
                    if (cnt_last) begin
                        r_state <= U_CHK;
                    end
                end
                U_CHK: begin
                    r_over <= hi_ge;
                    r_rem  <= DEN_W'(acc_hi);
                    r_cnt  <= '0;
                    if (hi_ge) begin
                        r_state <= U_IDLE;
                    end else begin
                        r_state <= U_DIV;
                    end
                end
                U_DIV: begin
                    // shift the dividend out and the quotient in, one bit a cycle
                    r_rem                <= n_rem;
                    r_acc[SCALE_W-1:0]   <= {r_acc[SCALE_W-2:0], div_ge};
                    r_cnt                <= r_cnt + STEP_W'(1);
                    if (cnt_last) begin
                        r_state <= U_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.over = r_over;
    assign o_rsp.quo  = r_acc[SCALE_W-1:0];

endmodule

/* hw/rtl/encoder_speed_estimator.sv */
// Encoder speed estimator (M/T method), top level.
// Depends on esp_pkg and esp_serial_unit.
//
// Input stream (s side): one transfer per sample carries position, now_us,
// step_interval_us and last_step_us; one result transfer (m side) follows
// each, with rpm (signed Q23.8, negated) in tdata and saturated in tuser.
// Config channel: a transfer on i_cfg_valid writes rpm_scale; it is always
// ready and is to be written only while no sample is in flight.
// Work per sample, from input transfer to result valid:
//   large move (more than 3 counts): a bit-serial multiply, an overflow
//     check and a restoring divide (the divide is skipped on overflow);
//   small move (period path): check and divide only;
//   zero sample time or zero interval: no serial work, straight to the result.
// One sample is worked on at a time; the next input is taken once the
// result has moved into the output register.
// A stalled receiver holds the output register; one further result may be
// computed behind it and waits until the register frees.
// Synchronous reset clears the output, the history (previous position, time
// and large move) and sets rpm_scale to its default.
module encoder_speed_estimator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [31:0] position, [63:32] now_us, [95:64] step_interval_us, [127:96] last_step_us
    input  logic [esp_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [31:0] rpm
    output logic [esp_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // [0] saturated
    output logic [esp_pkg::OUT_TUSER_W-1:0] o_m_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [esp_pkg::SCALE_W-1:0]   i_cfg_data
);
    import esp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_LAUNCH, S_WAIT, S_DONE} t_state;

    t_state                    r_state;
    logic [SCALE_W-1:0]        r_scale;
    logic [POS_W-1:0]          r_prev_pos;
    logic [TIME_W-1:0]         r_prev_time;
    logic [POS_W-1:0]          r_prev_big;
    logic signed [MOVE_W-1:0]  r_move;
    logic [TIME_W-1:0]         r_t;
    logic [TIME_W-1:0]         r_age;
    logic [POS_W-1:0]          r_e;
    logic                      r_big;
    logic signed [M2_W-1:0]    r_m2;
    logic [TIME_W-1:0]         r_ae;
    logic                      r_neg;
    logic [RPM_W-1:0]          r_res_rpm;
    logic                      r_res_sat;
    logic                      r_out_valid;
    logic [RPM_W-1:0]          r_out_rpm;
    logic                      r_out_sat;

    logic [POS_W-1:0]          in_pos;
    logic [TIME_W-1:0]         in_now;
    logic [POS_W-1:0]          in_step;
    logic [TIME_W-1:0]         in_last;
    logic [POS_W:0]            diff;
    logic signed [MOVE_W-1:0]  n_move;
    logic [TIME_W-1:0]         n_t;
    logic [TIME_W-1:0]         n_age;
    logic signed [CMPM_W-1:0]  mv_x;
    logic signed [CMPM_W-1:0]  pb_x;
    logic                      n_big;
    logic signed [M2_W-1:0]    m2_adj;
    logic signed [M2_W-1:0]    n_m2;
    logic [POS_W-1:0]          n_prev_big;
    logic [TIME_W-1:0]         e_abs;
    logic [TIME_W-1:0]         n_ae;
    logic signed [M2_W-1:0]    m2_negd;
    logic [MAG_W-1:0]          mag2;
    logic                      res_neg;
    logic [RPM_W-1:0]          res_lim;
    logic                      res_sat;
    logic [RPM_W-1:0]          res_mag;
    logic [RPM_W-1:0]          res_rpm;
    t_unit_req                 unit_req;
    t_unit_rsp                 unit_rsp;

    assign in_pos  = i_s_tdata[POS_W-1:0];
    assign in_now  = i_s_tdata[POS_W+TIME_W-1:POS_W];
    assign in_step = i_s_tdata[2*POS_W+TIME_W-1:POS_W+TIME_W];
    assign in_last = i_s_tdata[IN_TDATA_W-1:2*POS_W+TIME_W];

    assign diff   = {in_pos[POS_W-1], in_pos} - {r_prev_pos[POS_W-1], r_prev_pos};
    assign n_move = diff[MOVE_W-1:0];
    assign n_t    = in_now - r_prev_time;
    assign n_age  = in_now - in_last;

    assign mv_x  = CMPM_W'(r_move);
    assign pb_x  = CMPM_W'($signed(r_prev_big));
    assign n_big = (r_move > BIG_POS) || (r_move < BIG_NEG);

    // pull the doubled move half a count toward the previous large move
    always_comb begin
        priority if (mv_x < pb_x) begin
            m2_adj = M2_W'(1);
        end else if (mv_x > pb_x) begin
            m2_adj = M2_W'(-1);
        end else begin
            m2_adj = '0;
        end
    end

    assign n_m2 = (M2_W'(r_move) <<< 1) + m2_adj;

    always_comb begin
        priority if (mv_x > MV_MAX) begin
            n_prev_big = RPM_POS_LIM;
        end else if (mv_x < MV_MIN) begin
            n_prev_big = RPM_NEG_LIM;
        end else begin
            n_prev_big = mv_x[POS_W-1:0];
        end
    end

    // a stale interval stretches to the age of the last step
    assign e_abs = r_e[POS_W-1] ? (TIME_W'(0) - r_e) : r_e;
    assign n_ae  = (r_age > e_abs) ? r_age : e_abs;

    assign m2_negd = -r_m2;
    assign mag2    = r_m2[M2_W-1] ? m2_negd[MAG_W-1:0] : r_m2[MAG_W-1:0];

    assign unit_req.start = (r_state == S_LAUNCH) &&
                            (r_big ? (r_t != '0) : (r_ae != '0));
    assign unit_req.mul   = r_big;
    assign unit_req.scale = r_scale;
    assign unit_req.mag   = mag2;
    assign unit_req.den   = r_big ? {r_t, 1'b0} : {1'b0, r_ae};

    esp_serial_unit u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_rsp   (unit_rsp)
    );

    assign res_neg = r_neg && ((unit_rsp.quo != '0) || unit_rsp.over);
    assign res_lim = res_neg ? RPM_NEG_LIM : RPM_POS_LIM;
    assign res_sat = unit_rsp.over || (unit_rsp.quo > res_lim);
    assign res_mag = res_sat ? res_lim : unit_rsp.quo;
    assign res_rpm = res_neg ? (RPM_W'(0) - res_mag) : res_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scale     <= RPM_SCALE_RESET;
            r_prev_pos  <= '0;
            r_prev_time <= '0;
            r_prev_big  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_scale <= i_cfg_data;
            end
            if (r_out_valid && i_m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_move      <= n_move;
                        r_t         <= n_t;
                        r_age       <= n_age;
                        r_e         <= in_step;
                        r_prev_pos  <= in_pos;
                        r_prev_time <= in_now;
                        r_state     <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_big <= n_big;
                    r_m2  <= n_m2;
                    r_ae  <= n_ae;
                    if (n_big) begin
                        r_prev_big <= n_prev_big;
                    end
                    r_state <= S_LAUNCH;
                end
                S_LAUNCH: begin
                    if (r_big) begin
                        r_neg <= !r_m2[M2_W-1];
                        if (r_t == '0) begin
                            // zero sample time: full scale against the move, or zero for a zero scale
                            priority if (r_scale == '0) begin
                                r_res_rpm <= '0;
                            end else if (!r_m2[M2_W-1]) begin
                                r_res_rpm <= RPM_NEG_LIM;
                            end else begin
                                r_res_rpm <= RPM_POS_LIM;
                            end
                            r_res_sat <= 1'b1;
                            r_state   <= S_DONE;
                        end else begin
                            r_state <= S_WAIT;
                        end
                    end else begin
                        r_neg <= !r_e[POS_W-1];
                        if (r_ae == '0) begin
                            r_res_rpm <= '0;
                            r_res_sat <= 1'b1;
                            r_state   <= S_DONE;
                        end else begin
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (unit_rsp.done) begin
                        r_res_rpm <= res_rpm;
                        r_res_sat <= res_sat;
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free or being drained
                    if (!r_out_valid || i_m_tready) begin
                        r_out_rpm   <= r_res_rpm;
                        r_out_sat   <= r_res_sat;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_s_tready  = r_state == S_IDLE;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_rpm;
    assign o_m_tuser   = r_out_sat;
    assign o_cfg_ready = 1'b1;

endmodule

/* hw/rtl/esp_checker.sv */
// Port-level checks of the encoder speed estimator and their bind.
// Depends on esp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module esp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [esp_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [esp_pkg::OUT_TUSER_W-1:0] o_m_tuser
);
    import esp_pkg::*;

    // a stalled result holds its value
    `ASSERT_CLK(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")

    // reset empties the output register
    `ASSERT_CLK_NR(a_rst_clear, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

    // one sample at a time: input closes after each transfer
    `ASSERT_CLK(a_one_item, i_s_tvalid && o_s_tready |=> !o_s_tready, "input taken while busy")

    // no result rises while the sample just taken is still in the prepare or launch state
    `ASSERT_CLK(a_min_latency, $rose(o_m_tvalid) |-> !$past(i_s_tvalid && o_s_tready, 1) && !$past(i_s_tvalid && o_s_tready, 2), "result too early")

endmodule

bind encoder_speed_estimator esp_checker u_esp_checker (.*);

/* dv/tb_encoder_speed_estimator.sv */
// Self-checking testbench of encoder_speed_estimator: directed table then random samples.
// Checks each result against a built-in speed predictor or a given value; depends on esp_pkg and the RTL.
module tb_encoder_speed_estimator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 100;
    localparam int PHASE_ITEMS    = 165;
    localparam int PHASE_COUNT    = 7;

    typedef struct packed {
        logic [31:0] position;
        logic [31:0] now_us;
        logic [31:0] step_interval_us;
        logic [31:0] last_step_us;
    } sample_t;

    typedef struct packed {
        logic [31:0] rpm;
        logic        sat;
    } speed_t;

    typedef enum logic {ROW_SAMPLE, ROW_SCALE} row_kind_e;

    typedef struct {
        row_kind_e   kind;
        sample_t     smp;
        bit          known;
        speed_t      want;
        logic [31:0] scale;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [esp_pkg::IN_TDATA_W-1:0] i_s_tdata = '0;
    logic        i_m_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [esp_pkg::SCALE_W-1:0] i_cfg_data = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [esp_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic [esp_pkg::OUT_TUSER_W-1:0] o_m_tuser;
    logic        o_cfg_ready;

    // Predictor copy of the block state
    logic [31:0]        scale_reg = esp_pkg::RPM_SCALE_RESET;
    logic [31:0]        last_pos = '0;
    logic [31:0]        last_time = '0;
    logic signed [31:0] last_big_move = '0;

    speed_t      rpm_expected[$];
    row_t        plan[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    logic [31:0] gen_pos = '0;
    logic [31:0] gen_now = '0;

    encoder_speed_estimator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic speed_t clip_speed(bit neg, logic [63:0] mag, bit over);
        logic [63:0] lim;
        speed_t      r;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        r.sat = over || (mag > lim);
        if (r.sat) begin
            mag = lim;
        end
        r.rpm = neg ? (32'd0 - mag[31:0]) : mag[31:0];
        return r;
    endfunction

    function automatic speed_t estimate_speed(sample_t s);
        longint       raw;
        longint       mv;
        longint       m2;
        longint       prev_mv;
        longint       e;
        logic [31:0]  t;
        logic [31:0]  age;
        logic [63:0]  mag2;
        logic [63:0]  ae;
        logic [127:0] q;
        speed_t       r;
        raw = longint'($signed(s.position)) - longint'($signed(last_pos));
        // wrap the move to the counter width
        mv = (esp_pkg::COUNT_WIDTH < 64) ?
             ((raw <<< (64 - esp_pkg::COUNT_WIDTH)) >>> (64 - esp_pkg::COUNT_WIDTH)) : raw;
        if (mv > 3 || mv < -3) begin
            prev_mv = longint'(last_big_move);
            // damp by half a count toward the previous large move
            m2 = 2 * mv;
            if (mv < prev_mv) begin
                m2 = m2 + 1;
            end else if (mv > prev_mv) begin
                m2 = m2 - 1;
            end
            if (mv > 64'sh7FFF_FFFF) begin
                last_big_move = 32'h7FFF_FFFF;
            end else if (mv < -64'sh8000_0000) begin
                last_big_move = 32'h8000_0000;
            end else begin
                last_big_move = mv[31:0];
            end
            mag2 = (m2 < 0) ? -m2 : m2;
            t = s.now_us - last_time;
            if (t == 0) begin
                if (scale_reg == 0) begin
                    r.rpm = '0;
                    r.sat = 1'b1;
                end else begin
                    r = clip_speed(m2 > 0, 64'hFF_FFFF_FFFF, 1'b1);
                end
            end else begin
                q = (128'(scale_reg) * 128'(mag2)) / 128'({t, 1'b0});
                r = clip_speed(m2 > 0 && q != 0, q[63:0], q > 128'hFFFF_FFFF);
            end
        end else begin
            e = longint'($signed(s.step_interval_us));
            age = s.now_us - s.last_step_us;
            ae = (e < 0) ? -e : e;
            // stretch a stale interval so that speed decays
            if (64'(age) > ae) begin
                ae = 64'(age);
            end
            if (ae == 0) begin
                r.rpm = '0;
                r.sat = 1'b1;
            end else begin
                q = 128'(64'(scale_reg) / ae);
                r = clip_speed(e >= 0 && q != 0, q[63:0], 1'b0);
            end
        end
        last_time = s.now_us;
        last_pos = s.position;
        return r;
    endfunction

    function automatic void add_row(logic [31:0] pos, logic [31:0] now,
                                    logic [31:0] step, logic [31:0] last);
        row_t w;
        w.kind = ROW_SAMPLE;
        w.smp = {pos, now, step, last};
        w.known = 1'b0;
        w.want = '0;
        w.scale = '0;
        plan.push_back(w);
    endfunction

    function automatic void add_known(logic [31:0] pos, logic [31:0] now, logic [31:0] step,
                                      logic [31:0] last, logic [31:0] rpm, bit sat);
        add_row(pos, now, step, last);
        plan[plan.size() - 1].known = 1'b1;
        plan[plan.size() - 1].want = {rpm, sat};
    endfunction

    function automatic void add_scale(logic [31:0] v);
        row_t w;
        w.kind = ROW_SCALE;
        w.smp = '0;
        w.known = 1'b0;
        w.want = '0;
        w.scale = v;
        plan.push_back(w);
    endfunction

    function automatic sample_t random_sample();
        sample_t     s;
        int          d;
        int unsigned span;
        if ($urandom_range(99) < 10) begin
            // noise: every field fully random
            s = {$urandom, $urandom, $urandom, $urandom};
            gen_pos = s.position;
            gen_now = s.now_us;
            return s;
        end
        case ($urandom_range(5))
            0, 1: d = int'($urandom_range(6)) - 3;
            2: d = int'($urandom_range(8, 4)) * ($urandom_range(1) ? 1 : -1);
            3: d = int'($urandom_range(32'h10_0000)) * ($urandom_range(1) ? 1 : -1);
            4: d = $urandom;
            default: d = 0;
        endcase
        gen_pos = gen_pos + d;
        case ($urandom_range(9))
            0: span = 0;
            1: span = $urandom;
            default: span = $urandom_range(20000, 1);
        endcase
        gen_now = gen_now + span;
        s.position = gen_pos;
        s.now_us = gen_now;
        span = $urandom_range(60000);
        s.step_interval_us = $urandom_range(1) ? span : -span;
        s.last_step_us = gen_now - $urandom_range(2 * span + 10);
        if ($urandom_range(19) == 0) begin
            s.step_interval_us = $urandom;
        end
        if ($urandom_range(19) == 0) begin
            s.last_step_us = $urandom;
        end
        return s;
    endfunction

    task automatic send_sample(sample_t s, bit known, speed_t want);
        speed_t got;
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(99) < 13) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(80, 1)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {s.last_step_us, s.step_interval_us, s.now_us, s.position};
        do @(posedge i_clk); while (!o_s_tready);
        got = estimate_speed(s);
        rpm_expected.push_back(known ? want : got);
    endtask

    task automatic src_stop();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (rpm_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [31:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        scale_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls plus a single long hold-off
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !(sink_idle_en && $urandom_range(99) < 13);
        end
    end

    always @(posedge i_clk) begin : check_results
        speed_t want;
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_encoder_speed_estimator: FAIL");
                $finish;
            end else if (o_m_tvalid && i_m_tready) begin
                if (rpm_expected.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result rpm %h sat %b",
                                 $time, o_m_tdata, o_m_tuser[0]);
                    end
                end else begin
                    want = rpm_expected.pop_front();
                    if (o_m_tdata !== want.rpm || o_m_tuser[0] !== want.sat) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("%0t: expected rpm %h sat %b, got rpm %h sat %b", $time,
                                     want.rpm, want.sat, o_m_tdata, o_m_tuser[0]);
                        end
                    end
                end
            end
        end
    end

    initial begin
        // after reset: zero interval, then zero sample time both ways
        add_known(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        add_known(32'd100, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 1'b1);
        add_known(-32'sd100, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b1);
        // moves of 3 stay on the period path, moves of 4 take the count path
        add_row(-32'sd97, 32'd1000, 32'd1000, 32'd1000);
        add_row(-32'sd100, 32'd2000, -32'sd500, 32'd1800);
        add_row(-32'sd96, 32'd3000, 32'd250, 32'd2900);
        add_row(-32'sd100, 32'd4000, -32'sd250, 32'd3900);
        add_row(-32'sd96, 32'd5000, 32'd0, 32'd0);
        add_row(-32'sd92, 32'd6000, 32'd0, 32'd0);
        // stale interval, interval extremes, wrapping time and count
        add_row(-32'sd92, 32'd100000, 32'd100, 32'd0);
        add_row(-32'sd92, 32'd5, 32'h8000_0000, 32'd5);
        add_row(-32'sd92, 32'd6, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_row(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd2);
        add_row(32'h8000_0000, 32'd0, -32'sd1, 32'd0);
        add_scale(32'd0);
        add_known(32'h8000_0100, 32'd0, 32'd5, 32'd0, 32'd0, 1'b1);
        add_known(32'h8000_0100, 32'd10, 32'd7, 32'd3, 32'd0, 1'b0);
        add_scale(32'hFFFF_FFFF);
        add_known(32'h8000_0100, 32'd11, 32'd1, 32'd11, 32'h8000_0000, 1'b1);
        add_known(32'h8000_0100, 32'd12, -32'sd1, 32'd12, 32'h7FFF_FFFF, 1'b1);
        add_known(32'h7FFF_0000, 32'd13, 32'd9, 32'd13, 32'h7FFF_FFFF, 1'b1);
        add_scale(32'd1);
        add_row(32'h7FFF_0010, 32'd1013, 32'd40, 32'd1000);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_SCALE) begin
                src_stop();
                drain();
                write_scale(plan[k].scale);
            end else begin
                send_sample(plan[k].smp, plan[k].known, plan[k].want);
            end
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            src_stop();
            drain();
            case (ph)
                0: write_scale(esp_pkg::RPM_SCALE_RESET);
                1: write_scale($urandom);
                2: write_scale(32'hFFFF_FFFF);
                3: write_scale(32'd0);
                4: write_scale($urandom_range(255, 1));
                5: write_scale(32'd1);
                default: write_scale($urandom);
            endcase
            // one stretch with no idling on either side
            src_idle_en = (ph != 2);
            sink_idle_en = (ph != 2);
            if (ph == 3) begin
                hold_reqs = hold_reqs + 1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == PHASE_ITEMS / 2) begin
                    src_stop();
                    drain();
                end
                send_sample(random_sample(), 1'b0, '0);
            end
        end

        src_stop();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && rpm_expected.size() == 0) begin
            $display("tb_encoder_speed_estimator: PASS");
        end else begin
            $display("tb_encoder_speed_estimator: FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/esp_pkg.sv
hw/rtl/esp_serial_unit.sv
hw/rtl/encoder_speed_estimator.sv
hw/rtl/esp_checker.sv
dv/tb_encoder_speed_estimator.sv
